### rtl/core/spsc_pkg.sv
// Package for the stack pop sequence checker.
// Holds widths, register indexes, reset values and the stack memory request type.
// No dependencies.
`default_nettype none

package spsc_pkg;

  localparam int MaxDepth = 1024;
  localparam int AddrW    = $clog2(MaxDepth);
  localparam int PtrW     = AddrW + 1;
  localparam int ValW     = 16;
  localparam int CapW     = 11;
  localparam int LenW     = 16;
  localparam int CfgW     = 16;
  localparam int CfgIdxW  = 2;
  localparam int CmpW     = ((PtrW > ValW) ? PtrW : ValW) + 1;

  localparam logic [CfgIdxW-1:0] CfgIdxCapacity = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxLength   = CfgIdxW'(1);

  localparam logic [CapW-1:0] CapReset = CapW'(5);
  localparam logic [LenW-1:0] LenReset = LenW'(7);

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ValW-1:0]  wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

### rtl/core/spsc_if.sv
// Valid/ready channel interfaces for the stack pop sequence checker.
// Depends on spsc_pkg.
`default_nettype none

interface spsc_in_if
  import spsc_pkg::*;
  ;
  logic            valid;
  logic            ready;
  logic [ValW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface spsc_out_if;
  logic valid;
  logic ready;
  logic sequence_valid;

  modport source (output valid, output sequence_valid, input ready);
  modport sink   (input valid, input sequence_valid, output ready);
endinterface

`default_nettype wire

### rtl/core/stack_pop_sequence_checker_core.sv
// Top level of the stack pop sequence checker: configuration registers, sequencer, stack RAM.
// Depends on spsc_pkg, spsc_if, spsc_ctrl and spsc_ram.
//
//   channel | dir | payload               | transaction when
//   in_i    | in  | value [15:0]          | in_i.valid && in_i.ready
//   out_o   | out | sequence_valid [0:0]  | out_o.valid && out_o.ready
//   cfg     | in  | cfg_idx_i, cfg_data_i | cfg_we_i
//
// A value that pops first reads the stack RAM, then compares the read word in the StPop state.
// A value that pushes n integers writes all but the last of them to the stack RAM in StPush, one write per cycle.
// Items of an already invalid sequence, pushes over capacity and pops from an empty stack finish in StIdle.
// A finished result waits in the output register; the next value is still taken.
// A second result behind a stalled one holds the input until the output drains.
// Reset clears control state only; the stack RAM holds no reset value and needs no clearing.
`default_nettype none

module stack_pop_sequence_checker_core
  import spsc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  spsc_in_if.sink                 in_i,
  spsc_out_if.source              out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  logic [CapW-1:0] cap_q;
  logic [LenW-1:0] len_q;
  mem_req_t        mem_req;
  logic [ValW-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
      len_q <= LenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxCapacity: cap_q <= cfg_data_i[CapW-1:0];
        CfgIdxLength:   len_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  spsc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cap_i           (cap_q),
    .len_i           (len_q),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .in_value_i      (in_i.value),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_seq_valid_o (out_o.sequence_valid),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata)
  );

  spsc_ram #(
    .Depth (MaxDepth),
    .Width (ValW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

### rtl/core/spsc_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module spsc_ram #(
  parameter int Depth = 1024,
  parameter int Width = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/spsc_ctrl.sv
// Sequencer of the stack pop sequence checker: push burst, pop read, compare, result.
// Depends on spsc_pkg; drives the stack RAM through mem_req_t.
`default_nettype none

module spsc_ctrl
  import spsc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [CapW-1:0] cap_i,
  input  wire logic [LenW-1:0] len_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [ValW-1:0] in_value_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 out_seq_valid_o,
  output mem_req_t             mem_req_o,
  input  wire logic [ValW-1:0] mem_rdata_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPush = 2'd1;
  localparam logic [1:0] StPop  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [PtrW-1:0] sp_q, sp_d;
  logic [ValW-1:0] npv_q, npv_d;
  logic [LenW-1:0] items_q, items_d;
  logic            ok_q, ok_d;
  logic [ValW-1:0] val_q, val_d;
  logic [ValW-1:0] wcnt_q, wcnt_d;
  logic [ValW-1:0] wval_q, wval_d;
  logic [AddrW-1:0] waddr_q, waddr_d;
  logic            res_q, res_d;
  logic            out_valid_q, out_valid_d;
  logic            out_bit_q, out_bit_d;

  logic            accept;
  logic            slot_free;
  logic            fin;
  logic            fin_ok;
  logic [ValW-1:0] cnt;
  logic [CmpW-1:0] cap_lim;
  logic [CmpW-1:0] need;
  logic [LenW-1:0] items_inc;
  logic [PtrW-1:0] sp_dec;

  assign in_ready_o      = (state_q == StIdle);
  assign accept          = in_valid_i && in_ready_o;
  assign slot_free       = !out_valid_q || out_ready_i;
  assign cnt             = in_value_i - npv_q;
  assign cap_lim         = (CmpW'(cap_i) > CmpW'(MaxDepth)) ? CmpW'(MaxDepth) : CmpW'(cap_i);
  assign need            = CmpW'(sp_q) + CmpW'(cnt);
  assign items_inc       = items_q + LenW'(1);
  assign sp_dec          = sp_q - PtrW'(1);
  assign out_valid_o     = out_valid_q;
  assign out_seq_valid_o = out_bit_q;

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    npv_d       = npv_q;
    items_d     = items_q;
    ok_d        = ok_q;
    val_d       = val_q;
    wcnt_d      = wcnt_q;
    wval_d      = wval_q;
    waddr_d     = waddr_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_bit_d   = out_bit_q;
    fin         = 1'b0;
    fin_ok      = 1'b0;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = waddr_q;
    mem_req_o.wdata = wval_q;
    mem_req_o.raddr = sp_dec[AddrW-1:0];

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (!ok_q) begin
            fin = 1'b1;
          end else if (in_value_i > npv_q) begin
            if (need > cap_lim) begin
              fin = 1'b1;
            end else begin
              npv_d = in_value_i;
              sp_d  = PtrW'(need - CmpW'(1));
              if (cnt == ValW'(1)) begin
                fin    = 1'b1;
                fin_ok = 1'b1;
              end else begin
                wcnt_d  = cnt - ValW'(1);
                wval_d  = npv_q + ValW'(1);
                waddr_d = sp_q[AddrW-1:0];
                state_d = StPush;
              end
            end
          end else if (sp_q == '0) begin
            fin = 1'b1;
          end else begin
            sp_d    = sp_dec;
            val_d   = in_value_i;
            state_d = StPop;
          end
        end
      end
      StPush: begin
        mem_req_o.we = 1'b1;
        wcnt_d       = wcnt_q - ValW'(1);
        wval_d       = wval_q + ValW'(1);
        waddr_d      = waddr_q + AddrW'(1);
        if (wcnt_q == ValW'(1)) begin
          fin     = 1'b1;
          fin_ok  = 1'b1;
          state_d = StIdle;
        end
      end
      StPop: begin
        fin     = 1'b1;
        fin_ok  = (mem_rdata_i == val_q);
        state_d = StIdle;
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_bit_d   = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (fin) begin
      if (items_inc == len_i) begin
        sp_d    = '0;
        npv_d   = '0;
        items_d = '0;
        ok_d    = 1'b1;
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_bit_d   = fin_ok;
          state_d     = StIdle;
        end else begin
          res_d   = fin_ok;
          state_d = StEmit;
        end
      end else begin
        items_d = items_inc;
        ok_d    = fin_ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sp_q        <= '0;
      npv_q       <= '0;
      items_q     <= '0;
      ok_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      npv_q       <= npv_d;
      items_q     <= items_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    wcnt_q    <= wcnt_d;
    wval_q    <= wval_d;
    waddr_q   <= waddr_d;
    res_q     <= res_d;
    out_bit_q <= out_bit_d;
  end

endmodule

`default_nettype wire

### rtl/core/spsc_checker.sv
// Port-level assertions for the stack pop sequence checker, bound to the top level.
// Depends on stack_pop_sequence_checker_core.
`default_nettype none

module spsc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_seq_valid_i
);

  a_reset_no_result: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_seq_valid_i))
    else $error("stalled result dropped or changed");

  a_idle_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && !in_valid_i |=> in_ready_i)
    else $error("input ready dropped without a transaction");

endmodule

bind stack_pop_sequence_checker_core spsc_checker u_spsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_seq_valid_i (out_o.sequence_valid)
);

`default_nettype wire
